[src/sha256_pkg.sv]
// Shared types, constants and round functions for the SHA-256 hash engine.
// Used by sha256_sched, sha256_round and sha256_hash_engine; no dependencies.
`default_nettype none

package sha256_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic fold;
      logic reinit;
   } rnd_ctl_type;

   typedef struct packed {
      logic       byte_en;
      logic       word_en;
      logic [7:0] data;
   } sched_ctl_type;

   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] LAST_POS   = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD  = 3'd7;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

`default_nettype wire

[src/sha256_hash_engine.sv]
// Top level of the SHA-256 hash engine: sequencer, byte and length counters, digest output.
// Depends on sha256_pkg, sha256_sched and sha256_round.
//
// Message bytes enter at most one per item, one item per cycle while the block fills; the
// 64th byte of a block starts the 64 rounds on the single round unit, then a fold of the
// result into the chain hash, and req_stall is high throughout. The item marked end of
// message starts padding, written one byte per cycle up to the end of the block, then the
// rounds and the fold again. When the length does not fit in the open block, a second block
// of padding follows with its own rounds and fold; when the end mark comes with the 64th byte
// of a block, that block's rounds and fold run first and a full padding block follows. The
// eight digest words then leave one per cycle as rsp_stall allows, h0 first, the last one
// flagged; the next message is taken once the eighth word has gone.
`default_nettype none

module sha256_hash_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_msg_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_number,
   output logic             rsp_last_word
);

   sha256_pkg::state_type     state_ff, state_in;
   logic [5:0]                round_ff, round_in;
   logic [5:0]                pos_ff, pos_in;
   logic [60:0]               count_ff, count_in;
   logic [2:0]                out_idx_ff, out_idx_in;
   logic                      end_pend_ff, end_pend_in;
   logic                      first_pad_ff, first_pad_in;
   logic                      need_len_ff, need_len_in;
   logic [5:0]                pos_next;
   logic [63:0]               len_bits;
   logic [5:0]                len_sel;
   logic [7:0]                len_byte;
   logic [31:0]               w_word;
   sha256_pkg::rnd_ctl_type   rnd_ctl;
   sha256_pkg::sched_ctl_type sched_ctl;

   sha256_sched u_sched (
      .clock  (clock),
      .ctl    (sched_ctl),
      .w_word (w_word)
   );

   sha256_round u_round (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rnd_ctl),
      .round_idx (round_ff),
      .w_word    (w_word),
      .rd_idx    (out_idx_ff),
      .rd_word   (rsp_digest_word)
   );

   assign req_stall       = (state_ff != sha256_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == sha256_pkg::ST_OUT);
   assign rsp_word_number = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == sha256_pkg::LAST_WORD);
   assign len_bits        = {count_ff, 3'b000};
   assign len_sel         = {~pos_ff[2:0], 3'b000};
   assign len_byte        = len_bits[len_sel +: 8];

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      out_idx_in   = out_idx_ff;
      end_pend_in  = end_pend_ff;
      first_pad_in = first_pad_ff;
      need_len_in  = need_len_ff;
      pos_next     = pos_ff;
      rnd_ctl      = '0;
      sched_ctl    = '0;
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_has_byte) begin
                  pos_next          = pos_ff + 6'd1;
                  count_in          = count_ff + 61'd1;
                  sched_ctl.byte_en = 1'b1;
                  sched_ctl.data    = req_msg_byte;
               end
               pos_in = pos_next;
               if (req_end_of_message) begin
                  end_pend_in  = 1'b1;
                  first_pad_in = 1'b1;
                  need_len_in  = (pos_next < sha256_pkg::LEN_POS);
               end
               if (req_has_byte && pos_ff == sha256_pkg::LAST_POS) begin
                  rnd_ctl.load = 1'b1;
                  round_in     = '0;
                  state_in     = sha256_pkg::ST_ROUND;
               end else if (req_end_of_message) begin
                  state_in = sha256_pkg::ST_PAD;
               end
            end
         end
         sha256_pkg::ST_PAD: begin
            sched_ctl.byte_en = 1'b1;
            priority if (first_pad_ff) begin
               sched_ctl.data = sha256_pkg::PAD_MARKER;
            end else if (need_len_ff && pos_ff >= sha256_pkg::LEN_POS) begin
               sched_ctl.data = len_byte;
            end else begin
               sched_ctl.data = '0;
            end
            first_pad_in = 1'b0;
            pos_in       = pos_ff + 6'd1;
            if (pos_ff == sha256_pkg::LAST_POS) begin
               rnd_ctl.load = 1'b1;
               round_in     = '0;
               state_in     = sha256_pkg::ST_ROUND;
            end
         end
         sha256_pkg::ST_ROUND: begin
            rnd_ctl.step      = 1'b1;
            sched_ctl.word_en = 1'b1;
            round_in          = round_ff + 6'd1;
            if (round_ff == sha256_pkg::LAST_ROUND) begin
               state_in = sha256_pkg::ST_FOLD;
            end
         end
         sha256_pkg::ST_FOLD: begin
            rnd_ctl.fold = 1'b1;
            priority if (end_pend_ff && first_pad_ff) begin
               state_in = sha256_pkg::ST_PAD;
            end else if (end_pend_ff && need_len_ff) begin
               out_idx_in = '0;
               state_in   = sha256_pkg::ST_OUT;
            end else if (end_pend_ff) begin
               need_len_in = 1'b1;
               state_in    = sha256_pkg::ST_PAD;
            end else begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         sha256_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == sha256_pkg::LAST_WORD) begin
                  rnd_ctl.reinit = 1'b1;
                  count_in       = '0;
                  end_pend_in    = 1'b0;
                  state_in       = sha256_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha256_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha256_pkg::ST_IDLE;
         round_ff     <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         out_idx_ff   <= '0;
         end_pend_ff  <= 1'b0;
         first_pad_ff <= 1'b0;
         need_len_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         out_idx_ff   <= out_idx_in;
         end_pend_ff  <= end_pend_in;
         first_pad_ff <= first_pad_in;
         need_len_ff  <= need_len_in;
      end
   end

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item accepted while digest words are pending");

   a_fold_after_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha256_pkg::ST_FOLD) |->
         ($past(state_ff) == sha256_pkg::ST_ROUND && $past(round_ff) == sha256_pkg::LAST_ROUND))
      else $error("fold without a full set of rounds");

   a_digest_on_block_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pos_ff == '0 && end_pend_ff))
      else $error("digest output off a block boundary");

   a_last_word_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=> (!rsp_valid && !req_stall))
      else $error("output did not end after the last digest word");

endmodule

`default_nettype wire

[src/sha256_sched.sv]
// Message schedule: 64-byte window filled a byte at a time, then rolled a word per round.
// Depends on sha256_pkg for the control struct and the small sigma functions.
`default_nettype none

module sha256_sched (
   input  wire logic                      clock,
   input  wire sha256_pkg::sched_ctl_type ctl,
   output logic [31:0]                    w_word
);

   logic [511:0] win_ff;
   logic [511:0] win_in;
   logic [31:0]  next_word;

   assign w_word = win_ff[511:480];

   always_comb begin
      next_word = sha256_pkg::small_sigma1(win_ff[63:32]) + win_ff[223:192]
                + sha256_pkg::small_sigma0(win_ff[479:448]) + win_ff[511:480];
      win_in = win_ff;
      if (ctl.byte_en) begin
         win_in = {win_ff[503:0], ctl.data};
      end else if (ctl.word_en) begin
         win_in = {win_ff[479:0], next_word};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

[src/sha256_round.sv]
// Round unit: working variables a..h, one compression round per step, and the chain hash.
// Depends on sha256_pkg for the round constants, initial values and big sigma functions.
`default_nettype none

module sha256_round (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sha256_pkg::rnd_ctl_type ctl,
   input  wire logic [5:0]              round_idx,
   input  wire logic [31:0]             w_word,
   input  wire logic [2:0]              rd_idx,
   output logic [31:0]                  rd_word
);

   logic [31:0] vars_ff  [8];
   logic [31:0] vars_in  [8];
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] ch;
   logic [31:0] maj;

   assign rd_word = chain_ff[rd_idx];

   always_comb begin
      ch  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
      maj = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2]) ^ (vars_ff[1] & vars_ff[2]);
      t1  = vars_ff[7] + sha256_pkg::big_sigma1(vars_ff[4]) + ch
          + sha256_pkg::ROUND_K[round_idx] + w_word;
      t2  = sha256_pkg::big_sigma0(vars_ff[0]) + maj;
      vars_in = vars_ff;
      if (ctl.load) begin
         vars_in = chain_ff;
      end else if (ctl.step) begin
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end
      chain_in = chain_ff;
      if (ctl.reinit) begin
         chain_in = sha256_pkg::INIT_HASH;
      end else if (ctl.fold) begin
         for (int k = 0; k < 8; k++) begin
            chain_in[k] = chain_ff[k] + vars_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha256_pkg::INIT_HASH;
      end else begin
         chain_ff <= chain_in;
      end
   end

endmodule

`default_nettype wire
